### hdl/event_fragment_accumulator_assert.svh
// assertion macros shared by the accumulator modules
`ifndef EVENT_FRAGMENT_ACCUMULATOR_ASSERT_SVH
`define EVENT_FRAGMENT_ACCUMULATOR_ASSERT_SVH
// property that must hold at every clock edge outside reset
`define EFA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define EFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hdl/efa_pkg.sv
// types, codes and constants of the event fragment accumulator
package efa_pkg;
	localparam int unsigned EVENT_HEADER_BYTES_DEF = 32;
	localparam int unsigned FRAG_HEADER_BYTES_DEF = 20;
	localparam int unsigned CFG_W = 25;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [1:0] CFG_BUFFER_BYTES = 2'd0;
	localparam logic [1:0] CFG_MAX_FRAGMENTS = 2'd1;
	localparam logic [1:0] CFG_TIMESTAMP_POLICY = 2'd2;
	localparam logic [1:0] CFG_FLUSH_TICKS = 2'd3;

	localparam logic [1:0] KIND_FRAG = 2'd0;
	localparam logic [1:0] KIND_OOB = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_DRAIN = 2'd3;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_LAST = 2'd1;
	localparam logic [1:0] POL_AVG = 2'd2;

	localparam logic [2:0] REC_CLOSE = 3'd0;
	localparam logic [2:0] REC_FLUSH = 3'd1;
	localparam logic [2:0] REC_PLACE = 3'd2;
	localparam logic [2:0] REC_OOB = 3'd3;
	localparam logic [2:0] REC_BIG = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] timestamp;
		logic [31:0] frag_source;
		logic [31:0] barrier;
		logic [24:0] payload_bytes;
		logic [31:0] item_type;
		logic [31:0] output_sid;
		logic        has_body_header;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  record;
		logic [24:0] offset;
		logic [24:0] length;
		logic [63:0] event_time;
		logic [31:0] event_type;
		logic [31:0] event_sid;
		logic [31:0] event_barrier;
		logic [15:0] fragment_total;
		logic [24:0] fragment_bytes;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_DIV, ST_CLOSE, ST_FLUSH_CHK, ST_FLUSH,
		ST_PLACE, ST_OOB, ST_BIG, ST_WAIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input item
		logic tick;
		logic div_start;
		logic emit_close;
		logic emit_flush;
		logic emit_place;
		logic emit_oob;
		logic emit_big;
		logic emit_last;
		logic clr_ticks;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic too_big;
		logic need_close;
		logic need_div;
		logic event_open;
		logic flush_due;
		logic flush_gives;
		logic div_busy;
		logic out_busy;
	} sts_t;
endpackage

### hdl/efa_divider.sv
// serial 64 by 16 bit restoring divider, one quotient bit per cycle
module efa_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [6:0]  cnt_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], quo_q[63]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;
endmodule

### hdl/efa_datapath.sv
// bookkeeping registers, tests and result register of the accumulator
`include "event_fragment_accumulator_assert.svh"
module efa_datapath #(
	parameter int unsigned EVENT_HEADER_BYTES = efa_pkg::EVENT_HEADER_BYTES_DEF,
	parameter int unsigned FRAG_HEADER_BYTES = efa_pkg::FRAG_HEADER_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [24:0]            cfg_data,
	input  efa_pkg::in_item_t      in_item,
	input  efa_pkg::cmd_t          cmd,
	output efa_pkg::sts_t          sts,
	output logic                   out_valid,
	input  logic                   out_ready,
	output efa_pkg::out_item_t     out_item
);
	localparam logic [26:0] EHB = 27'(EVENT_HEADER_BYTES);
	localparam logic [26:0] FHB = 27'(FRAG_HEADER_BYTES);

	logic [24:0] buffer_bytes_q;
	logic [15:0] max_fragments_q;
	logic [1:0]  policy_q;
	logic [15:0] flush_ticks_q;

	efa_pkg::in_item_t item_q;
	logic        event_open_q;
	logic [24:0] event_start_q, bytes_held_q, open_size_q, open_frag_bytes_q;
	logic [31:0] open_type_q, open_sid_q, open_barrier_q;
	logic [63:0] first_time_q, latest_time_q, time_sum_q;
	logic [15:0] open_count_q, ticks_q;
	logic        out_valid_q;
	efa_pkg::out_item_t out_q;
	efa_pkg::out_item_t out_d;

	logic [26:0] fsize, need, room;
	logic        div_busy;
	logic [63:0] quotient;
	logic [63:0] close_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_bytes_q <= 25'd1048576;
			max_fragments_q <= 16'd1024;
			policy_q <= efa_pkg::POL_FIRST;
			flush_ticks_q <= 16'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efa_pkg::CFG_BUFFER_BYTES:     buffer_bytes_q <= cfg_data;
				efa_pkg::CFG_MAX_FRAGMENTS:    max_fragments_q <= cfg_data[15:0];
				efa_pkg::CFG_TIMESTAMP_POLICY: policy_q <= cfg_data[1:0];
				efa_pkg::CFG_FLUSH_TICKS:      flush_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
	end

	assign fsize = FHB + {2'b0, item_q.payload_bytes};
	assign need = fsize + (event_open_q ? 27'd0 : EHB);
	assign room = {2'b0, buffer_bytes_q} - {2'b0, bytes_held_q};

	efa_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(time_sum_q), .divisor(open_count_q),
		.busy(div_busy), .quotient(quotient)
	);

	always_comb begin
		close_time = first_time_q;
		if (policy_q == efa_pkg::POL_LAST) close_time = latest_time_q;
		else if (policy_q == efa_pkg::POL_AVG && open_count_q != 16'd0)
			close_time = quotient;
	end

	always_comb begin
		sts.kind = item_q.kind;
		sts.too_big = (EHB + fsize) > {2'b0, buffer_bytes_q};
		sts.need_close = event_open_q && (item_q.item_type != open_type_q ||
			item_q.output_sid != open_sid_q || open_count_q >= max_fragments_q ||
			fsize + {2'b0, open_size_q} > {2'b0, buffer_bytes_q});
		sts.need_div = policy_q == efa_pkg::POL_AVG && open_count_q != 16'd0;
		sts.event_open = event_open_q;
		sts.flush_due = bytes_held_q > buffer_bytes_q || need > room ||
			ticks_q >= flush_ticks_q;
		sts.flush_gives = bytes_held_q != 25'd0 &&
			(!event_open_q || event_start_q != 25'd0);
		sts.div_busy = div_busy;
		sts.out_busy = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_open_q <= 1'b0;
			event_start_q <= '0;
			bytes_held_q <= '0;
			open_type_q <= '0;
			open_sid_q <= '0;
			open_barrier_q <= '0;
			first_time_q <= '0;
			latest_time_q <= '0;
			time_sum_q <= '0;
			open_count_q <= '0;
			open_size_q <= '0;
			open_frag_bytes_q <= '0;
			ticks_q <= '0;
		end else begin
			if (cmd.tick && ticks_q != 16'hFFFF) ticks_q <= ticks_q + 16'd1;
			if (cmd.clr_ticks) ticks_q <= '0;
			if (cmd.emit_close) event_open_q <= 1'b0;
			if (cmd.emit_flush) begin
				if (event_open_q) begin
					bytes_held_q <= open_size_q;
					event_start_q <= '0;
				end else begin
					bytes_held_q <= '0;
				end
			end
			if (cmd.emit_place) begin
				latest_time_q <= item_q.timestamp;
				if (!event_open_q) begin
					event_open_q <= 1'b1;
					event_start_q <= bytes_held_q;
					open_type_q <= item_q.item_type;
					open_sid_q <= item_q.output_sid;
					open_barrier_q <= item_q.barrier;
					first_time_q <= item_q.timestamp;
					time_sum_q <= item_q.timestamp;
					open_count_q <= 16'd1;
					open_size_q <= 25'(EHB + fsize);
					open_frag_bytes_q <= fsize[24:0];
					bytes_held_q <= 25'({2'b0, bytes_held_q} + EHB + fsize);
				end else begin
					time_sum_q <= time_sum_q + item_q.timestamp;
					open_count_q <= open_count_q + 16'd1;
					open_size_q <= 25'({2'b0, open_size_q} + fsize);
					open_frag_bytes_q <= 25'({2'b0, open_frag_bytes_q} + fsize);
					bytes_held_q <= 25'({2'b0, bytes_held_q} + fsize);
				end
			end
		end
	end

	logic [24:0] place_off;
	assign place_off = event_open_q ? bytes_held_q : 25'({2'b0, bytes_held_q} + EHB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_close || cmd.emit_flush || cmd.emit_place ||
			cmd.emit_oob || cmd.emit_big) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d = '0;
		out_d.last = cmd.emit_last;
		if (cmd.emit_close) begin
			out_d.record = efa_pkg::REC_CLOSE;
			out_d.offset = event_start_q;
			out_d.length = open_size_q;
			out_d.event_time = close_time;
			out_d.event_type = open_type_q;
			out_d.event_sid = open_sid_q;
			out_d.event_barrier = open_barrier_q;
			out_d.fragment_total = open_count_q;
			out_d.fragment_bytes = open_frag_bytes_q;
		end else if (cmd.emit_flush) begin
			out_d.record = efa_pkg::REC_FLUSH;
			out_d.offset = event_open_q ? event_start_q : 25'd0;
			out_d.length = event_open_q ? event_start_q : bytes_held_q;
		end else if (cmd.emit_place) begin
			out_d.record = efa_pkg::REC_PLACE;
			out_d.offset = place_off;
			out_d.length = fsize[24:0];
		end else if (cmd.emit_oob) begin
			out_d.record = efa_pkg::REC_OOB;
			out_d.length = item_q.payload_bytes;
			out_d.event_time = item_q.timestamp;
			out_d.event_type = item_q.item_type;
			out_d.event_sid = item_q.has_body_header ? item_q.output_sid : 32'd0;
		end else begin
			out_d.record = efa_pkg::REC_BIG;
			out_d.length = fsize[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_close || cmd.emit_flush || cmd.emit_place ||
			cmd.emit_oob || cmd.emit_big) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`EFA_ASSERT_NEXT(a_flush_clears_ticks, cmd.clr_ticks && !cmd.tick, ticks_q == 16'd0,
		"flush left tick count")
	`EFA_ASSERT(a_one_emit, $onehot0({cmd.emit_close, cmd.emit_flush, cmd.emit_place,
		cmd.emit_oob, cmd.emit_big}), "two results at once")
	`EFA_ASSERT(a_emit_free, !((cmd.emit_close || cmd.emit_flush || cmd.emit_place ||
		cmd.emit_oob || cmd.emit_big) && out_valid_q), "result register overwritten")
	`EFA_ASSERT_NEXT(a_place_opens, cmd.emit_place, event_open_q, "no open event after place")
endmodule

### hdl/efa_controller.sv
// sequencing state machine of the accumulator
`include "event_fragment_accumulator_assert.svh"
module efa_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  efa_pkg::sts_t     sts,
	output efa_pkg::cmd_t     cmd
);
	efa_pkg::state_t state_q, state_d;
	logic kind_frag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efa_pkg::ST_IDLE;
			kind_frag_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == efa_pkg::ST_DECIDE)
				kind_frag_q <= sts.kind == efa_pkg::KIND_FRAG;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			efa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = efa_pkg::ST_DECIDE;
				end
			end
			efa_pkg::ST_DECIDE: begin
				unique case (sts.kind)
					efa_pkg::KIND_TICK: begin
						cmd.tick = 1'b1;
						state_d = efa_pkg::ST_IDLE;
					end
					efa_pkg::KIND_OOB: state_d = efa_pkg::ST_FLUSH;
					efa_pkg::KIND_DRAIN: begin
						if (!sts.event_open) state_d = efa_pkg::ST_FLUSH;
						else if (sts.need_div) begin
							cmd.div_start = 1'b1;
							state_d = efa_pkg::ST_DIV;
						end else state_d = efa_pkg::ST_CLOSE;
					end
					default: begin
						if (sts.too_big) state_d = efa_pkg::ST_BIG;
						else if (!sts.need_close) state_d = efa_pkg::ST_FLUSH_CHK;
						else if (sts.need_div) begin
							cmd.div_start = 1'b1;
							state_d = efa_pkg::ST_DIV;
						end else state_d = efa_pkg::ST_CLOSE;
					end
				endcase
			end
			efa_pkg::ST_DIV: begin
				if (!sts.div_busy) state_d = efa_pkg::ST_CLOSE;
			end
			efa_pkg::ST_CLOSE: begin
				if (!sts.out_busy) begin
					// a closed event always leaves bytes held, so a place or a flush follows
					cmd.emit_close = 1'b1;
					cmd.emit_last = 1'b0;
					state_d = kind_frag_q ? efa_pkg::ST_FLUSH_CHK : efa_pkg::ST_FLUSH;
				end
			end
			efa_pkg::ST_FLUSH_CHK: begin
				state_d = sts.flush_due ? efa_pkg::ST_FLUSH : efa_pkg::ST_PLACE;
			end
			efa_pkg::ST_FLUSH: begin
				if (!sts.flush_gives) begin
					cmd.clr_ticks = 1'b1;
					state_d = kind_frag_q ? efa_pkg::ST_PLACE :
						(sts.kind == efa_pkg::KIND_OOB ? efa_pkg::ST_OOB : efa_pkg::ST_WAIT);
				end else if (!sts.out_busy) begin
					cmd.clr_ticks = 1'b1;
					cmd.emit_flush = 1'b1;
					cmd.emit_last = sts.kind == efa_pkg::KIND_DRAIN;
					state_d = kind_frag_q ? efa_pkg::ST_PLACE :
						(sts.kind == efa_pkg::KIND_OOB ? efa_pkg::ST_OOB : efa_pkg::ST_WAIT);
				end
			end
			efa_pkg::ST_PLACE: begin
				if (!sts.out_busy) begin
					cmd.emit_place = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = efa_pkg::ST_WAIT;
				end
			end
			efa_pkg::ST_OOB: begin
				if (!sts.out_busy) begin
					cmd.emit_oob = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = efa_pkg::ST_WAIT;
				end
			end
			efa_pkg::ST_BIG: begin
				if (!sts.out_busy) begin
					cmd.emit_big = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = efa_pkg::ST_WAIT;
				end
			end
			efa_pkg::ST_WAIT: begin
				// last result is in the output register, next item may enter
				state_d = efa_pkg::ST_IDLE;
			end
			default: state_d = efa_pkg::ST_IDLE;
		endcase
	end

	`EFA_ASSERT(a_ready_idle, in_ready == (state_q == efa_pkg::ST_IDLE), "ready outside idle")
	`EFA_ASSERT_NEXT(a_div_wait, cmd.div_start, state_q == efa_pkg::ST_DIV,
		"divide without wait")
endmodule

### hdl/event_fragment_accumulator.sv
// top level of the event fragment accumulator
// Groups fragment headers into built events and reports the bookkeeping.
// in channel: in_valid/in_ready transfer one in_item (fragment, out-of-band,
// tick or drain). out channel: out_valid/out_ready transfer one out_item;
// an item gives zero to three results, the final one has last set.
// configuration: cfg_we, cfg_index, cfg_data, to be written only while idle
// by the user; the block itself does not enforce this. A close under the
// average policy waits for the serial 64-bit divider.
// the single output register lets the next item enter while the last result
// waits; a stalled receiver holds the sequencer before its next result.
// reset clears all bookkeeping and sets the registers to their defaults.
module event_fragment_accumulator #(
	parameter int unsigned EVENT_HEADER_BYTES = efa_pkg::EVENT_HEADER_BYTES_DEF,
	parameter int unsigned FRAG_HEADER_BYTES = efa_pkg::FRAG_HEADER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [24:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  efa_pkg::in_item_t     in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output efa_pkg::out_item_t    out_item
);
	efa_pkg::cmd_t cmd;
	efa_pkg::sts_t sts;

	efa_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	efa_datapath #(
		.EVENT_HEADER_BYTES(EVENT_HEADER_BYTES),
		.FRAG_HEADER_BYTES(FRAG_HEADER_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule
